/* rtl/gaps_pkg.sv */
// ----------------------------------------------------------------------------
// gaps_pkg
// Shared types and constants of the grid path search engine.
// ----------------------------------------------------------------------------
package gaps_pkg;

	localparam int SIDE  = 16;
	localparam int CELLS = SIDE * SIDE;
	localparam int IDX_W = $clog2(CELLS);
	localparam int LEN_W = IDX_W + 1;

	// operation codes of a request item
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_PATH = 2'd1;
	localparam logic [1:0] STATUS_RANGE   = 2'd2;

	// configuration register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [4:0] REG_RESET = 5'd10;

	// move directions, in relaxation order
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] row_addr;
		logic [3:0] col_addr;
		logic       cell_blocked;
		logic [3:0] goal_row;
		logic [3:0] goal_col;
		logic [7:0] path_index;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] path_length;
		logic [3:0] step_row;
		logic [3:0] step_col;
	} res_item_t;

	typedef enum logic [2:0] {
		K_WRITE,
		K_SEARCH,
		K_SEARCH_OFF,
		K_READ,
		K_BAD
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] loc;
		logic       blocked;
		logic [7:0] goal;
		logic [7:0] index;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_SCAN_LAST,
		S_PICK,
		S_NBR,
		S_RELAX,
		S_WALK,
		S_WALK_STEP
	} state_t;

endpackage

/* rtl/gaps_front.sv */
// ----------------------------------------------------------------------------
// gaps_front
// Classifies request items into engine commands and range checks cells.
// ----------------------------------------------------------------------------
module gaps_front (
	input  gaps_pkg::req_item_t req,
	input  logic [4:0]          rows_use,
	input  logic [4:0]          cols_use,
	output gaps_pkg::cmd_t      cmd
);

	logic start_in;
	logic goal_in;

	assign start_in = ({1'b0, req.row_addr} < rows_use) && ({1'b0, req.col_addr} < cols_use);
	assign goal_in  = ({1'b0, req.goal_row} < rows_use) && ({1'b0, req.goal_col} < cols_use);

	always_comb begin
		cmd.loc     = {req.row_addr, req.col_addr};
		cmd.blocked = req.cell_blocked;
		cmd.goal    = {req.goal_row, req.goal_col};
		cmd.index   = req.path_index;
		case (req.operation)
			gaps_pkg::OP_WRITE:  cmd.kind = start_in ? gaps_pkg::K_WRITE : gaps_pkg::K_BAD;
			gaps_pkg::OP_SEARCH: begin
				cmd.kind = (start_in && goal_in) ? gaps_pkg::K_SEARCH : gaps_pkg::K_SEARCH_OFF;
			end
			gaps_pkg::OP_READ:   cmd.kind = gaps_pkg::K_READ;
			default:             cmd.kind = gaps_pkg::K_BAD;
		endcase
	end

endmodule

/* rtl/gaps_cmdq.sv */
// ----------------------------------------------------------------------------
// gaps_cmdq
// Two-entry command queue between classifier and engine.
// ----------------------------------------------------------------------------
module gaps_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  gaps_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           rd,
	output logic           avail,
	output gaps_pkg::cmd_t rd_cmd
);

	gaps_pkg::cmd_t ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign avail  = (cnt_q != 2'd0);
	assign rd_cmd = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/gaps_back.sv */
// ----------------------------------------------------------------------------
// gaps_back
// Engine: obstacle writes, A* search with open-cell scan, path walk, reads.
// ----------------------------------------------------------------------------
module gaps_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_avail,
	input  gaps_pkg::cmd_t        cmd,
	output logic                  cmd_take,
	input  logic [4:0]            rows_use,
	input  logic [4:0]            cols_use,
	input  logic                  pop,
	output logic                  empty,
	output gaps_pkg::res_item_t   result
);

	localparam int IW = gaps_pkg::IDX_W;
	localparam int LW = gaps_pkg::LEN_W;

	gaps_pkg::state_t state_q, state_d;

	logic [gaps_pkg::CELLS-1:0] obst_q, obst_d;
	logic [gaps_pkg::CELLS-1:0] open_q, open_d;
	logic [gaps_pkg::CELLS-1:0] reached_q, reached_d;
	logic [LW-1:0]              len_q, len_d;
	gaps_pkg::res_item_t        res_q, res_d;
	logic                       res_vld_q, res_vld_d;
	logic [IW-1:0]              start_q, start_d;
	logic [IW-1:0]              goal_q, goal_d;
	logic [IW-1:0]              scan_i_q, scan_i_d;
	logic                       scan_vld_s1, scan_vld_d;
	logic [IW-1:0]              scan_idx_s1, scan_idx_d;
	logic                       scan_open_s1, scan_open_d;
	logic                       found_q, found_d;
	logic [IW-1:0]              best_q, best_d;
	logic [9:0]                 bestf_q, bestf_d;
	logic [7:0]                 bestg_q, bestg_d;
	logic [1:0]                 dir_q, dir_d;
	logic [IW-1:0]              nbr_q, nbr_d;
	logic [IW-1:0]              at_q, at_d;
	logic [LW-1:0]              n_q, n_d;

	// memories
	logic [7:0]    cost_mem [gaps_pkg::CELLS];
	logic [1:0]    par_mem  [gaps_pkg::CELLS];
	logic [IW-1:0] path_mem [gaps_pkg::CELLS];
	logic [7:0]    cost_rd_q;
	logic [1:0]    par_rd_q;
	logic [IW-1:0] path_rd_q;

	logic          cost_we, par_we, path_we;
	logic [IW-1:0] cost_wa, cost_ra, par_wa, path_wa, path_ra;
	logic [7:0]    cost_wd;
	logic [IW-1:0] path_wd;

	// combinational helpers
	logic [3:0] hr, hc;
	logic [9:0] f_val;
	logic [4:0] nr5, nc5;
	logic [IW-1:0] ni;
	logic       nbr_ok;
	logic [7:0] newc;
	logic [4:0] wr5, wc5;
	logic [LW-1:0] rd_off;

	assign empty  = !res_vld_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (cost_we) cost_mem[cost_wa] <= cost_wd;
		cost_rd_q <= cost_mem[cost_ra];
		if (par_we) par_mem[par_wa] <= dir_q;
		par_rd_q <= par_mem[at_q];
		if (path_we) path_mem[path_wa] <= path_wd;
		path_rd_q <= path_mem[path_ra];
	end

	always_comb begin
		hr = (goal_q[7:4] > scan_idx_s1[7:4]) ? goal_q[7:4] - scan_idx_s1[7:4]
		                                       : scan_idx_s1[7:4] - goal_q[7:4];
		hc = (goal_q[3:0] > scan_idx_s1[3:0]) ? goal_q[3:0] - scan_idx_s1[3:0]
		                                       : scan_idx_s1[3:0] - goal_q[3:0];
		f_val = {2'b00, cost_rd_q} + {6'd0, hr} + {6'd0, hc};

		// neighbor of best in direction dir_q: up, down, left, right
		nr5 = {1'b0, best_q[7:4]};
		nc5 = {1'b0, best_q[3:0]};
		case (dir_q)
			gaps_pkg::DIR_UP:   nr5 = {1'b0, best_q[7:4]} - 5'd1;
			gaps_pkg::DIR_DOWN: nr5 = {1'b0, best_q[7:4]} + 5'd1;
			gaps_pkg::DIR_LEFT: nc5 = {1'b0, best_q[3:0]} - 5'd1;
			default:            nc5 = {1'b0, best_q[3:0]} + 5'd1;
		endcase
		ni     = {nr5[3:0], nc5[3:0]};
		nbr_ok = (nr5 < rows_use) && (nc5 < cols_use) && !obst_q[ni];
		newc   = bestg_q + 8'd1;

		// step back along the parent direction
		wr5 = {1'b0, at_q[7:4]};
		wc5 = {1'b0, at_q[3:0]};
		case (par_rd_q)
			gaps_pkg::DIR_UP:   wr5 = {1'b0, at_q[7:4]} + 5'd1;
			gaps_pkg::DIR_DOWN: wr5 = {1'b0, at_q[7:4]} - 5'd1;
			gaps_pkg::DIR_LEFT: wc5 = {1'b0, at_q[3:0]} + 5'd1;
			default:            wc5 = {1'b0, at_q[3:0]} - 5'd1;
		endcase

		rd_off = len_q - {{(LW-1){1'b0}}, 1'b1} - {1'b0, cmd.index};
	end

	always_comb begin
		state_d     = state_q;
		obst_d      = obst_q;
		open_d      = open_q;
		reached_d   = reached_q;
		len_d       = len_q;
		res_d       = res_q;
		res_vld_d   = res_vld_q && !pop;
		start_d     = start_q;
		goal_d      = goal_q;
		scan_i_d    = scan_i_q;
		scan_vld_d  = 1'b0;
		scan_idx_d  = scan_idx_s1;
		scan_open_d = scan_open_s1;
		found_d     = found_q;
		best_d      = best_q;
		bestf_d     = bestf_q;
		bestg_d     = bestg_q;
		dir_d       = dir_q;
		nbr_d       = nbr_q;
		at_d        = at_q;
		n_d         = n_q;
		cmd_take    = 1'b0;
		cost_we     = 1'b0;
		cost_wa     = nbr_q;
		cost_wd     = newc;
		cost_ra     = scan_i_q;
		par_we      = 1'b0;
		par_wa      = nbr_q;
		path_we     = 1'b0;
		path_wa     = n_q[IW-1:0];
		path_wd     = at_q;
		path_ra     = rd_off[IW-1:0];

		// fold the scanned cell into the running minimum
		if ((state_q == gaps_pkg::S_SCAN || state_q == gaps_pkg::S_SCAN_LAST) &&
		    scan_vld_s1 && scan_open_s1) begin
			if (!found_q || f_val < bestf_q) begin
				found_d = 1'b1;
				best_d  = scan_idx_s1;
				bestf_d = f_val;
				bestg_d = cost_rd_q;
			end
		end

		case (state_q)
			gaps_pkg::S_IDLE: begin
				if (cmd_avail && !res_vld_q) begin
					cmd_take  = 1'b1;
					res_vld_d = 1'b1;
					res_d     = '{gaps_pkg::STATUS_OK, len_q, 4'd0, 4'd0};
					case (cmd.kind)
						gaps_pkg::K_WRITE: begin
							obst_d[cmd.loc] = cmd.blocked;
						end
						gaps_pkg::K_SEARCH: begin
							res_vld_d      = 1'b0;
							len_d          = '0;
							open_d         = '0;
							open_d[cmd.loc] = 1'b1;
							reached_d      = '0;
							start_d        = cmd.loc;
							goal_d         = cmd.goal;
							cost_we        = 1'b1;
							cost_wa        = cmd.loc;
							cost_wd        = 8'd0;
							scan_i_d       = '0;
							found_d        = 1'b0;
							state_d        = gaps_pkg::S_SCAN;
						end
						gaps_pkg::K_SEARCH_OFF: begin
							len_d = '0;
							res_d = '{gaps_pkg::STATUS_RANGE, {LW{1'b0}}, 4'd0, 4'd0};
						end
						gaps_pkg::K_READ: begin
							if ({1'b0, cmd.index} < len_q) begin
								res_vld_d = 1'b0;
								state_d   = gaps_pkg::S_READ;
							end else begin
								res_d.status = gaps_pkg::STATUS_RANGE;
							end
						end
						default: res_d.status = gaps_pkg::STATUS_RANGE;
					endcase
				end
			end
			gaps_pkg::S_READ: begin
				res_vld_d = 1'b1;
				res_d     = '{gaps_pkg::STATUS_OK, len_q, path_rd_q[7:4], path_rd_q[3:0]};
				state_d   = gaps_pkg::S_IDLE;
			end
			gaps_pkg::S_SCAN: begin
				scan_vld_d  = 1'b1;
				scan_idx_d  = scan_i_q;
				scan_open_d = open_q[scan_i_q];
				scan_i_d    = scan_i_q + 1'b1;
				if (scan_i_q == IW'(gaps_pkg::CELLS - 1)) begin
					state_d = gaps_pkg::S_SCAN_LAST;
				end
			end
			gaps_pkg::S_SCAN_LAST: begin
				state_d = gaps_pkg::S_PICK;
			end
			gaps_pkg::S_PICK: begin
				if (!found_q) begin
					res_vld_d = 1'b1;
					res_d     = '{gaps_pkg::STATUS_NO_PATH, {LW{1'b0}}, 4'd0, 4'd0};
					state_d   = gaps_pkg::S_IDLE;
				end else begin
					open_d[best_q]    = 1'b0;
					reached_d[best_q] = 1'b1;
					if (best_q == goal_q) begin
						at_d    = goal_q;
						n_d     = '0;
						state_d = gaps_pkg::S_WALK;
					end else begin
						dir_d   = gaps_pkg::DIR_UP;
						state_d = gaps_pkg::S_NBR;
					end
				end
			end
			gaps_pkg::S_NBR: begin
				if (nbr_ok) begin
					cost_ra = ni;
					nbr_d   = ni;
					state_d = gaps_pkg::S_RELAX;
				end else if (dir_q == gaps_pkg::DIR_RIGHT) begin
					scan_i_d = '0;
					found_d  = 1'b0;
					state_d  = gaps_pkg::S_SCAN;
				end else begin
					dir_d = dir_q + 2'd1;
				end
			end
			gaps_pkg::S_RELAX: begin
				if ((!open_q[nbr_q] && !reached_q[nbr_q]) || newc < cost_rd_q) begin
					cost_we           = 1'b1;
					par_we            = 1'b1;
					open_d[nbr_q]     = 1'b1;
					reached_d[nbr_q]  = 1'b0;
				end
				if (dir_q == gaps_pkg::DIR_RIGHT) begin
					scan_i_d = '0;
					found_d  = 1'b0;
					state_d  = gaps_pkg::S_SCAN;
				end else begin
					dir_d   = dir_q + 2'd1;
					state_d = gaps_pkg::S_NBR;
				end
			end
			gaps_pkg::S_WALK: begin
				// path_mem holds the walk goal-first; reads index from the far end
				path_we = 1'b1;
				n_d     = n_q + 1'b1;
				if (at_q == start_q || n_q == LW'(gaps_pkg::CELLS - 1)) begin
					len_d     = n_q + 1'b1;
					res_vld_d = 1'b1;
					res_d     = '{gaps_pkg::STATUS_OK, n_q + 1'b1, 4'd0, 4'd0};
					state_d   = gaps_pkg::S_IDLE;
				end else begin
					state_d = gaps_pkg::S_WALK_STEP;
				end
			end
			gaps_pkg::S_WALK_STEP: begin
				if (wr5[4] || wc5[4]) begin
					len_d     = n_q;
					res_vld_d = 1'b1;
					res_d     = '{gaps_pkg::STATUS_OK, n_q, 4'd0, 4'd0};
					state_d   = gaps_pkg::S_IDLE;
				end else begin
					at_d    = {wr5[3:0], wc5[3:0]};
					state_d = gaps_pkg::S_WALK;
				end
			end
			default: state_d = gaps_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		scan_idx_s1  <= scan_idx_d;
		scan_open_s1 <= scan_open_d;
		res_q        <= res_d;
		start_q      <= start_d;
		goal_q       <= goal_d;
		scan_i_q     <= scan_i_d;
		best_q       <= best_d;
		bestf_q      <= bestf_d;
		bestg_q      <= bestg_d;
		dir_q        <= dir_d;
		nbr_q        <= nbr_d;
		at_q         <= at_d;
		n_q          <= n_d;
		open_q       <= open_d;
		reached_q    <= reached_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gaps_pkg::S_IDLE;
			obst_q      <= '0;
			len_q       <= '0;
			res_vld_q   <= 1'b0;
			scan_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			obst_q      <= obst_d;
			len_q       <= len_d;
			res_vld_q   <= res_vld_d;
			scan_vld_s1 <= scan_vld_d;
			found_q     <= found_d;
		end
	end

endmodule

/* rtl/grid_astar_path_search.sv */
// ----------------------------------------------------------------------------
// grid_astar_path_search
// A* shortest-path engine on a 16x16 four-connected occupancy grid.
// ----------------------------------------------------------------------------
// Push request items; each gives exactly one result item, in order. For each
// cell it expands, a search makes a full pass over all 256 cells through the
// single read port of the cost memory to pick the open cell of least f, then
// relaxes the four neighbors; once the goal is picked, the path is walked
// back from the goal. A two-entry command queue sits between the classifier
// and the engine, so up to two further items are taken while a search runs
// and one finished result waits in the output register. rows_in_use and
// cols_in_use (reset 10, clamped to 16) must only be written while the block
// is idle.
// ----------------------------------------------------------------------------
module grid_astar_path_search (
	input  logic                clk,
	input  logic                arst_n,
	// request side
	input  logic                push,
	output logic                full,
	input  gaps_pkg::req_item_t request,
	// result side
	input  logic                pop,
	output logic                empty,
	output gaps_pkg::res_item_t result,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [4:0]          cfg_data
);

	logic [4:0]     rows_q, cols_q;
	logic [4:0]     rows_use, cols_use;
	gaps_pkg::cmd_t cmd_in, cmd_out;
	logic           q_avail, q_take;

	assign cfg_ready = 1'b1;

	// usable grid size: register clamped to the physical side
	assign rows_use = (rows_q > 5'(gaps_pkg::SIDE)) ? 5'(gaps_pkg::SIDE) : rows_q;
	assign cols_use = (cols_q > 5'(gaps_pkg::SIDE)) ? 5'(gaps_pkg::SIDE) : cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gaps_pkg::REG_RESET;
			cols_q <= gaps_pkg::REG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				gaps_pkg::REG_ROWS: rows_q <= cfg_data;
				gaps_pkg::REG_COLS: cols_q <= cfg_data;
				default:            rows_q <= rows_q;
			endcase
		end
	end

	// front: classify and range check each item
	gaps_front u_front (
		.req      (request),
		.rows_use (rows_use),
		.cols_use (cols_use),
		.cmd      (cmd_in)
	);

	gaps_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push && !full),
		.wr_cmd (cmd_in),
		.full   (full),
		.rd     (q_take),
		.avail  (q_avail),
		.rd_cmd (cmd_out)
	);

	// back: search engine with its own result register
	gaps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (q_avail),
		.cmd       (cmd_out),
		.cmd_take  (q_take),
		.rows_use  (rows_use),
		.cols_use  (cols_use),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
